FILE: sv/speaker_impulse_iir_synth_defines.svh
// Assertion macros for the speaker impulse synthesizer checker.
// Included by the checker file; depends on clk and rst_n in the including scope.
`ifndef SPEAKER_IMPULSE_IIR_SYNTH_DEFINES_SVH
`define SPEAKER_IMPULSE_IIR_SYNTH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sis_pkg.sv
// Shared types, constants, coefficient table and saturation helpers.
// No dependencies; imported by every module of the synthesizer.
`timescale 1ns / 1ps

package sis_pkg;

    localparam int NUM_STAGES  = 28;
    localparam int MAX_STAGES  = 32;
    localparam int QUEUE_DEPTH = 64;

    localparam int STAGE_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int QA_W    = $clog2(QUEUE_DEPTH);
    localparam int QC_W    = QA_W + 1;
    localparam int STEP_W  = 4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(9);

    // Request codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PUSH  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CPS = 2'd0;
    localparam logic [1:0] CFG_PAD = 2'd1;
    localparam logic [1:0] CFG_BUF = 2'd2;

    localparam logic [15:0] CPS_RESET = 16'd108;
    localparam logic [15:0] PAD_RESET = 16'd4410;
    localparam logic [19:0] BUF_RESET = 20'd65536;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] timestamp;
    } sis_in_t;

    typedef struct packed {
        logic signed [22:0] pcm_sample;
        logic               last_sample;
        logic               queue_overflow;
    } sis_out_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic               start;
        logic               push;
        logic               sub;
        logic               evt;
        logic               filt;
        logic               tail;
        logic               link;
        logic               finish;
        logic [STEP_W-1:0]  step;
        logic [STAGE_W-1:0] stage;
    } sis_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } sis_status_t;

    typedef logic signed [32:0] coef_t;
    typedef coef_t coef_row_t [5];

    localparam coef_t ONE = 33'sd1073741824;
    localparam coef_t TWO = 33'sd2147483648;

    // Nearest integer to (i + 0.h l) * 2^30, h and l nine decimal digits each.
    function automatic coef_t qf(input longint unsigned i, input longint unsigned h,
                                 input longint unsigned l);
        longint unsigned frac;
        frac = ((h << 30) + ((l << 30) / 64'd1000000000) + 64'd500000000)
               / 64'd1000000000;
        return coef_t'((i << 30) + frac);
    endfunction

    // High-pass section: b = 1, -2, 1.
    function automatic coef_row_t hp(input longint unsigned h1, input longint unsigned l1,
                                     input longint unsigned h2, input longint unsigned l2);
        coef_row_t r;
        r[0] = ONE;
        r[1] = -TWO;
        r[2] = ONE;
        r[3] = -qf(1, h1, l1);
        r[4] = qf(0, h2, l2);
        return r;
    endfunction

    // Order in each row: b0, b1, b2, a1, a2.
    localparam coef_row_t COEF_ROM [MAX_STAGES] = '{
        '{qf(0, 9053953, 112749067), -qf(0, 18107906, 225498134),
          qf(0, 9053953, 112749067), -qf(1, 979637479, 539993800),
          qf(0, 979842716, 618198300)},
        hp(981673613, 851291400, 981840024, 139423500),
        hp(983506166, 450813100, 983641081, 639581000),
        hp(985155486, 977734000, 985264857, 972096600),
        hp(986639892, 397609900, 986728548, 373465600),
        hp(987975869, 656543300, 988047728, 780995600),
        hp(989178258, 233558400, 989236498, 995740400),
        hp(990260414, 557890400, 990307615, 20683200),
        hp(991234360, 72709200, 991272611, 13174800),
        hp(992110914, 557119400, 992141911, 363654800),
        hp(992899816, 163347000, 992924933, 457620500),
        hp(993609829, 484899800, 993630181, 700993500),
        hp(994248842, 843328000, 994265333, 395753700),
        hp(994823955, 864898600, 994837317, 46939200),
        hp(995341558, 313204100, 995352383, 667335400),
        hp(995807401, 48457000, 995816171, 624917200),
        hp(996226659, 898122600, 996233765, 552482100),
        hp(996603993, 145807500, 996609749, 810532700),
        hp(996943593, 275137600, 996948256, 964543100),
        hp(997249233, 542087000, 997253011, 707283600),
        hp(997524309, 892146200, 997527370, 626528400),
        hp(997771878, 687279100, 997774358, 188793100),
        hp(997994690, 661298900, 997996699, 281127300),
        hp(998195221, 480505200, 998196848, 625601100),
        hp(998375699, 248846400, 998377017, 355245300),
        hp(998538129, 262999600, 998539197, 15852100),
        '{ONE, TWO, ONE, -qf(1, 960395132, 981931600), qf(0, 962397655, 153192800)},
        hp(985953901, 369927400, 986219511, 50537000),
        '{ONE, 33'sd0, 33'sd0, 33'sd0, 33'sd0},
        '{ONE, 33'sd0, 33'sd0, 33'sd0, 33'sd0},
        '{ONE, 33'sd0, 33'sd0, 33'sd0, 33'sd0},
        '{ONE, 33'sd0, 33'sd0, 33'sd0, 33'sd0}
    };

    function automatic logic signed [47:0] sat48(input logic signed [53:0] v);
        if (v[53:47] == {7{v[47]}})
            return v[47:0];
        return v[53] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [33:0] sat34(input logic signed [34:0] v);
        if (v[34] == v[33])
            return v[33:0];
        return v[34] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
    endfunction

    function automatic logic signed [22:0] sat23(input logic signed [40:0] v);
        if (v[40:22] == {19{v[22]}})
            return v[22:0];
        return v[40] ? {1'b1, 22'd0} : {1'b0, {22{1'b1}}};
    endfunction

endpackage

FILE: sv/sis_ctrl.sv
// Sequencer of the synthesizer: request decode, stage and step counters.
// Depends on sis_pkg; drives the datapath by sis_cmd_t.
`timescale 1ns / 1ps

module sis_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [1:0]           req_type,
    output logic                 req_stall,
    input  sis_pkg::sis_status_t status,
    output sis_pkg::sis_cmd_t    cmd
);
    import sis_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUB  = 6'b000010,
        ST_EVT  = 6'b000100,
        ST_FILT = 6'b001000,
        ST_TAIL = 6'b010000,
        ST_DONE = 6'b100000
    } sis_state_t;

    sis_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STAGE_W-1:0]  stage_reg, stage_next;
    logic                accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        stage_next = stage_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.stage  = stage_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_START: cmd.start = 1'b1;
                        REQ_PUSH:  cmd.push = 1'b1;
                        REQ_TICK:
                        begin
                            if (status.active)
                                state_next = ST_SUB;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_EVT;
            end
            ST_EVT:
            begin
                cmd.evt    = 1'b1;
                step_next  = '0;
                stage_next = '0;
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.filt = 1'b1;
                cmd.link = (stage_reg != '0);
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (stage_reg == STAGE_W'(NUM_STAGES - 1))
                        state_next = ST_TAIL;
                    else
                        stage_next = stage_reg + 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                cmd.tail = 1'b1;
                cmd.link = 1'b1;
                if (step_reg[0])
                    state_next = ST_DONE;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            stage_reg <= stage_next;
        end
    end

endmodule

FILE: sv/sis_dp.sv
// Datapath: config registers, timestamp queue, clock budget, biquad state
// memories, shared multiplier with accumulator, and the result register.
// Depends on sis_pkg; controlled by sis_cmd_t from sis_ctrl.
`timescale 1ns / 1ps

module sis_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sis_pkg::sis_in_t     req_data,
    input  sis_pkg::sis_cmd_t    cmd,
    output sis_pkg::sis_status_t status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sis_pkg::sis_out_t    rsp_data
);
    import sis_pkg::*;

    // Configuration.
    logic [15:0] cps_reg, pad_reg;
    logic [19:0] buf_reg;

    // Queue.
    logic [31:0]     queue_mem [QUEUE_DEPTH];
    logic [31:0]     q_rd_reg;
    logic [QA_W-1:0] head_reg, head_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic [QC_W-1:0] wr_sum;
    logic [QA_W-1:0] wr_addr;
    logic            q_write;

    // Effect control.
    logic signed [33:0] cl_reg, cl_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic               ovf_reg, ovf_next;
    logic               active_reg, active_next;
    logic [19:0]        samples_reg, samples_next;
    logic [19:0]        limit_reg, limit_next;
    logic [20:0]        cap;
    logic signed [31:0] delta;
    logic [19:0]        smn;
    logic               last;

    // Filter.
    logic signed [47:0] x_reg, x_next;
    logic signed [47:0] y_reg, y_next;
    logic signed [52:0] tmp1_reg, tmp1_next;
    logic signed [51:0] tmp2_reg, tmp2_next;
    logic signed [57:0] preg;
    logic signed [81:0] acc_reg, acc_next;
    logic signed [51:0] fx;
    logic signed [32:0] coef_sel;
    logic signed [24:0] opnd;
    logic signed [47:0] opnd_full;
    logic signed [47:0] s1_mem [NUM_STAGES];
    logic signed [47:0] s2_mem [NUM_STAGES];
    logic signed [47:0] s1_rd_reg, s2_rd_reg, s1_eff, s2_eff;
    logic               rd_vld_reg;
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [STAGE_W-1:0] pstage_reg;
    logic               s1_write, s2_write;
    logic signed [47:0] s1_new, s2_new;
    logic signed [48:0] pcm_sum;

    // Result register.
    logic     out_valid_reg, out_valid_next;
    sis_out_t out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg <= CPS_RESET;
            pad_reg <= PAD_RESET;
            buf_reg <= BUF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CPS: cps_reg <= cfg_data[15:0];
                CFG_PAD: pad_reg <= cfg_data[15:0];
                CFG_BUF: buf_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Queue write address wraps at the queue depth.
    assign wr_sum  = QC_W'(head_reg) + count_reg;
    assign wr_addr = (wr_sum >= QC_W'(QUEUE_DEPTH)) ? QA_W'(wr_sum - QC_W'(QUEUE_DEPTH))
                                                     : QA_W'(wr_sum);
    assign q_write = cmd.push && (count_reg < QC_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (q_write)
            queue_mem[wr_addr] <= req_data.timestamp;
        q_rd_reg <= queue_mem[head_reg];
    end

    assign delta = $signed(q_rd_reg - last_time_reg);
    assign cap   = 21'(samples_reg) + 21'(pad_reg);
    assign smn   = samples_reg + 20'd1;
    assign last  = (smn >= limit_reg) || (smn == 20'd0);

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        cl_next        = cl_reg;
        last_time_next = last_time_reg;
        neg_next       = neg_reg;
        done_next      = done_reg;
        ovf_next       = ovf_reg;
        active_next    = active_reg;
        samples_next   = samples_reg;
        limit_next     = limit_reg;
        x_next         = x_reg;
        if (cmd.start)
        begin
            samples_next   = '0;
            limit_next     = buf_reg;
            last_time_next = req_data.timestamp;
            cl_next        = '0;
            neg_next       = 1'b0;
            done_next      = 1'b0;
            active_next    = (buf_reg != '0);
        end
        if (cmd.push)
        begin
            if (q_write)
                count_next = count_reg + 1'b1;
            else
                ovf_next = 1'b1;
        end
        if (cmd.sub && !done_reg)
            cl_next = sat34({cl_reg[33], cl_reg} - 35'(cps_reg));
        if (cmd.evt)
        begin
            x_next = '0;
            if (!done_reg && cl_reg[33])
            begin
                x_next   = neg_reg ? -48'sd1073741824 : 48'sd1073741824;
                neg_next = !neg_reg;
                if (count_reg == '0)
                begin
                    if (cap < 21'(limit_reg))
                        limit_next = cap[19:0];
                    done_next = 1'b1;
                end
                else
                begin
                    head_next      = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : head_reg + 1'b1;
                    count_next     = count_reg - 1'b1;
                    cl_next        = sat34({cl_reg[33], cl_reg} + 35'(delta));
                    last_time_next = q_rd_reg;
                end
            end
        end
        if (cmd.filt && cmd.step == STEP_LAST)
            x_next = y_reg;
        if (cmd.finish)
        begin
            samples_next = smn;
            if (last)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            cl_reg        <= '0;
            last_time_reg <= '0;
            neg_reg       <= 1'b0;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            active_reg    <= 1'b0;
            samples_reg   <= '0;
            limit_reg     <= BUF_RESET;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            cl_reg        <= cl_next;
            last_time_reg <= last_time_next;
            neg_reg       <= neg_next;
            done_reg      <= done_next;
            ovf_reg       <= ovf_next;
            active_reg    <= active_next;
            samples_reg   <= samples_next;
            limit_reg     <= limit_next;
        end
    end

    // Shared multiplier: even steps take the low 24 operand bits, odd steps the
    // high 24; steps pair up as b0, b1, b2 on x and a1, a2 on y.
    assign coef_sel  = COEF_ROM[cmd.stage][cmd.step[3:1]];
    assign opnd_full = (cmd.step < STEP_W'(6)) ? x_reg : y_reg;
    assign opnd      = cmd.step[0] ? {opnd_full[47], opnd_full[47:24]}
                                   : {1'b0, opnd_full[23:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.filt)
            preg <= coef_sel * opnd;
    end

    // Rounded product, valid once the high half has been added.
    assign fx = acc_reg[81:30];

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.filt || cmd.tail)
        begin
            if (cmd.step[0])
                acc_next = {{24{preg[57]}}, preg} + 82'sd536870912;
            else
                acc_next = acc_reg + {preg, 24'd0};
        end
    end

    assign s1_eff = rd_vld_reg ? s1_rd_reg : '0;
    assign s2_eff = rd_vld_reg ? s2_rd_reg : '0;
    assign s1_new = sat48({tmp1_reg[52], tmp1_reg} - {{2{fx[51]}}, fx});
    assign s2_new = sat48({{2{tmp2_reg[51]}}, tmp2_reg} - {{2{fx[51]}}, fx});
    assign s1_write = cmd.filt && cmd.step == STEP_LAST;
    assign s2_write = (cmd.filt || cmd.tail) && cmd.link && cmd.step == STEP_W'(1);

    always_comb
    begin
        y_next    = y_reg;
        tmp1_next = tmp1_reg;
        tmp2_next = tmp2_reg;
        vld_next  = vld_reg;
        if (cmd.filt)
        begin
            case (cmd.step)
                STEP_W'(3): y_next = sat48({{2{fx[51]}}, fx} + {{6{s1_eff[47]}}, s1_eff});
                STEP_W'(5): tmp1_next = {{5{s2_eff[47]}}, s2_eff} + {fx[51], fx};
                STEP_W'(7): tmp2_next = fx;
                default: ;
            endcase
        end
        if (s2_write)
            vld_next[pstage_reg] = 1'b1;
        if (cmd.start)
            vld_next = '0;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        y_reg    <= y_next;
        x_reg    <= x_next;
        tmp1_reg <= tmp1_next;
        tmp2_reg <= tmp2_next;
        if (s1_write)
        begin
            s1_mem[cmd.stage] <= s1_new;
            pstage_reg        <= cmd.stage;
        end
        if (s2_write)
            s2_mem[pstage_reg] <= s2_new;
        if (cmd.filt && cmd.step == '0)
        begin
            s1_rd_reg  <= s1_mem[cmd.stage];
            s2_rd_reg  <= s2_mem[cmd.stage];
            rd_vld_reg <= vld_reg[cmd.stage];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Result register.
    assign pcm_sum = {y_reg[47], y_reg} + 49'sd128;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.pcm_sample     <= sat23(pcm_sum[48:8]);
            out_reg.last_sample    <= last;
            out_reg.queue_overflow <= ovf_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_data        = out_reg;
    assign status.active   = active_reg;
    assign status.out_free = !out_valid_reg || !rsp_stall;

endmodule

FILE: sv/speaker_impulse_iir_synth.sv
// Top level of the speaker impulse synthesizer: sequencer plus datapath.
// Depends on sis_pkg, sis_ctrl and sis_dp.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  sis_in_t  (req_type, timestamp)
//   rsp      out        rsp_valid / rsp_stall  sis_out_t (pcm_sample, last_sample,
//                                                          queue_overflow)
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A start or push item leaves the sequencer idle and does not hold the request
// channel. A tick item of an active effect passes through the budget update, the
// impulse decision, the filter sections and a drain of the last section before its
// sample is in the output register; all products go through the single shared
// 33 x 25 multiplier, each coefficient product in two halves, five per section.
// Reset is asynchronous and active low; the filter state is cleared through
// per-section valid bits, so no clearing pass is needed after reset or start.
// A stalled sample waits in the output register; the next item is taken
// meanwhile, and a following tick holds only in its last cycle until the
// register is free.
`timescale 1ns / 1ps

module speaker_impulse_iir_synth (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sis_pkg::sis_in_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sis_pkg::sis_out_t rsp_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [19:0]       cfg_data
);
    import sis_pkg::*;

    sis_cmd_t    cmd;
    sis_status_t status;

    // The sequencer walks each tick of an active effect through budget update, impulse
    // decision, ten multiplier steps per section and a two-step drain of the last section.
    sis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds all architectural state and the output register.
    sis_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

FILE: sv/sis_checker.sv
// Port-level checks of the speaker impulse synthesizer, bound to its top level.
// Depends on sis_pkg and speaker_impulse_iir_synth_defines.svh.
`timescale 1ns / 1ps
`include "speaker_impulse_iir_synth_defines.svh"

module sis_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input sis_pkg::sis_in_t  req_data,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input sis_pkg::sis_out_t rsp_data
);
    import sis_pkg::*;

    // A stalled sample stays offered and unchanged.
    `SIS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled sample changed")

    // A start item does not hold the request channel.
    `SIS_ASSERT_NEXT(a_start_quick, req_valid && !req_stall && req_data.req_type == REQ_START, !req_stall, "start item held the request channel")

    // Once reported, the overflow flag stays set on every later sample.
    `SIS_ASSERT_NEXT(a_ovf_sticky, rsp_valid && rsp_data.queue_overflow, !rsp_valid || rsp_data.queue_overflow, "overflow flag cleared")

    // A push never produces a sample.
    `SIS_ASSERT_NEXT(a_push_silent, req_valid && !req_stall && req_data.req_type == REQ_PUSH && !rsp_valid, !rsp_valid, "sample after a push")

endmodule

bind speaker_impulse_iir_synth sis_checker u_sis_checker (.*);
